>>> rtl/core/combination_unrank_defines.svh
// Assertion macros shared by the RTL of the combination unrank block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef COMBINATION_UNRANK_DEFINES_SVH
`define COMBINATION_UNRANK_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("combination_unrank: assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("combination_unrank: assertion failed");

`endif

>>> rtl/core/cu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cu_pkg;

  // Fixed widths of the datapath and of the configuration port.
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned BINOM_W     = 63;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_LEN_DEF = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH_N = 2'd0,
    CFG_WEIGHT_K = 2'd1
  } cfg_idx_e;

  // Operations of the shared add/subtract unit.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e             op;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]   y;
    logic                borrow;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/cu_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module cu_alu (
  input  cu_pkg::alu_req_t req_i,
  output cu_pkg::alu_rsp_t rsp_o
);
  import cu_pkg::*;

  logic [DATA_W:0] sum;

  // One wide adder serves both the table build and the rank compare.
  // For a subtraction the top bit flags a borrow, meaning b is greater than a.
  always_comb begin
    if (req_i.op == ALU_ADD) begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end
    rsp_o.y      = sum[DATA_W-1:0];
    rsp_o.borrow = (req_i.op == ALU_SUB) && sum[DATA_W];
  end

endmodule

`default_nettype wire

>>> rtl/core/combination_unrank.sv
`timescale 1ns / 1ps
`default_nettype none
`include "combination_unrank_defines.svh"

// Maps a 64-bit rank to the n-bit string of weight k at that rank in
// lexicographic order (position 0 most significant, returned in bit 0).
// Set length_n (index 0) and weight_k (index 1) through the write port while
// the block is idle. After reset the block builds a Pascal triangle of
// (MAX_LEN+1)^2 entries in an internal memory, and rank_ready_o stays low
// meanwhile. Each of the n positions of an item then needs one memory read
// and one pass through the shared 64-bit subtractor. The result sits in an
// output register, so a new rank can be taken while it waits.
// A weight above the length, a length above MAX_LEN or a rank not below
// C(n,k) returns bad_rank_o set and an all-zero string.
module combination_unrank #(
  parameter int unsigned MAX_LEN = cu_pkg::MAX_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cu_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                          rank_valid_i,
  output logic                          rank_ready_o,
  input  logic [cu_pkg::DATA_W-1:0]     rank_index_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [cu_pkg::DATA_W-1:0]     combination_bits_o,
  output logic                          bad_rank_o
);
  import cu_pkg::*;

  localparam int unsigned ROW   = MAX_LEN + 1;
  localparam int unsigned IW    = $clog2(ROW);
  localparam int unsigned DEPTH = ROW * ROW;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_FILL_RD,
    S_FILL_WR,
    S_IDLE,
    S_CHK_RD,
    S_CHK,
    S_STEP_RD,
    S_STEP,
    S_DONE
  } state_e;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(ROW) + AW'(c);
  endfunction

  state_e              state_q;
  logic [CFG_W-1:0]    length_n_q;
  logic [CFG_W-1:0]    weight_k_q;
  logic [IW-1:0]       fill_i_q;
  logic [IW-1:0]       fill_j_q;
  logic [BINOM_W-1:0]  fill_prev_q;
  logic [DATA_W-1:0]   rank_q;
  logic [IW-1:0]       kcur_q;
  logic [IW-1:0]       pos_left_q;
  logic [DATA_W-1:0]   mask_q;
  logic [DATA_W-1:0]   bits_q;
  logic                bad_q;
  logic                res_valid_q;
  logic [DATA_W-1:0]   res_bits_q;
  logic                res_bad_q;
  logic                res_load;

  logic [BINOM_W-1:0]  mem [DEPTH];
  logic [BINOM_W-1:0]  rdata_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [BINOM_W-1:0]  mem_wdata;
  logic [AW-1:0]       mem_raddr;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  cu_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Configuration registers; writes to other indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_n_q <= '0;
      weight_k_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LENGTH_N: length_n_q <= cfg_data_i;
        CFG_WEIGHT_K: weight_k_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Memory addresses, write data and the shared unit's operands per state.
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = addr_of(fill_i_q, fill_j_q);
    mem_wdata   = '0;
    mem_raddr   = '0;
    alu_req.op  = ALU_SUB;
    alu_req.a   = rank_q;
    alu_req.b   = {1'b0, rdata_q};
    case (state_q)
      S_FILL_RD: begin
        if (fill_j_q == '0) begin
          mem_we    = 1'b1;
          mem_wdata = BINOM_W'(1);
        end else if (fill_i_q == '0) begin
          mem_we    = 1'b1;
        end else begin
          mem_raddr = addr_of(fill_i_q - 1'b1, fill_j_q - 1'b1);
        end
      end
      S_FILL_WR: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {1'b0, fill_prev_q};
        mem_we     = 1'b1;
        mem_wdata  = alu_rsp.y[BINOM_W-1:0];
      end
      S_CHK_RD:  mem_raddr = addr_of(IW'(length_n_q), IW'(weight_k_q));
      S_STEP_RD: mem_raddr = addr_of(pos_left_q - 1'b1, kcur_q);
      default: ;
    endcase
  end

  // Binomial table with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // A finished item moves to the output register once that is free.
  assign res_load = (state_q == S_DONE) && (!res_valid_q || res_ready_i);

  // Sequencer: table build after reset, then each position in a read state and a compare state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL_RD;
      fill_i_q    <= '0;
      fill_j_q    <= '0;
      fill_prev_q <= '0;
      rank_q      <= '0;
      kcur_q      <= '0;
      pos_left_q  <= '0;
      mask_q      <= '0;
      bits_q      <= '0;
      bad_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_bits_q  <= '0;
      res_bad_q   <= 1'b0;
    end else begin
      // Output register: load a finished item, or drop the result once taken.
      if (res_load) begin
        res_valid_q <= 1'b1;
        res_bits_q  <= bad_q ? '0 : bits_q;
        res_bad_q   <= bad_q;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_FILL_RD: begin
          if (fill_j_q == '0 || fill_i_q == '0) begin
            fill_prev_q <= '0;
            if (fill_i_q == IW'(MAX_LEN)) begin
              fill_i_q <= '0;
              fill_j_q <= fill_j_q + 1'b1;
            end else begin
              fill_i_q <= fill_i_q + 1'b1;
            end
          end else begin
            state_q <= S_FILL_WR;
          end
        end
        S_FILL_WR: begin
          fill_prev_q <= alu_rsp.y[BINOM_W-1:0];
          if (fill_i_q == IW'(MAX_LEN)) begin
            fill_i_q <= '0;
            if (fill_j_q == IW'(MAX_LEN)) begin
              state_q <= S_IDLE;
            end else begin
              fill_j_q <= fill_j_q + 1'b1;
              state_q  <= S_FILL_RD;
            end
          end else begin
            fill_i_q <= fill_i_q + 1'b1;
            state_q  <= S_FILL_RD;
          end
        end
        S_IDLE: begin
          if (rank_valid_i) begin
            rank_q  <= rank_index_i;
            bits_q  <= '0;
            mask_q  <= DATA_W'(1);
            bad_q   <= 1'b0;
            state_q <= S_CHK_RD;
          end
        end
        S_CHK_RD: begin
          pos_left_q <= IW'(length_n_q);
          kcur_q     <= IW'(weight_k_q);
          if (length_n_q > CFG_W'(MAX_LEN) || weight_k_q > length_n_q) begin
            bad_q   <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          // A rank at or above C(n,k) has no string.
          if (!alu_rsp.borrow) begin
            bad_q   <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_STEP_RD;
          end
        end
        S_STEP_RD: begin
          if (pos_left_q == '0) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          // Take the position when the binomial does not exceed the rank.
          if (!alu_rsp.borrow) begin
            rank_q <= alu_rsp.y;
            bits_q <= bits_q | mask_q;
            if (kcur_q != '0) begin
              kcur_q <= kcur_q - 1'b1;
            end
          end
          mask_q     <= mask_q << 1;
          pos_left_q <= pos_left_q - 1'b1;
          state_q    <= S_STEP_RD;
        end
        S_DONE: begin
          if (res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rank_ready_o       = (state_q == S_IDLE);
  assign res_valid_o        = res_valid_q;
  assign combination_bits_o = res_bits_q;
  assign bad_rank_o         = res_bad_q;

  // A rejected request never carries set bits.
  `CU_ASSERT_NOW(a_bad_is_zero, res_valid_o && bad_rank_o, combination_bits_o == '0)
  // A served request has exactly k ones.
  `CU_ASSERT_NOW(a_weight_kept, res_valid_o && !bad_rank_o,
                 $countones(combination_bits_o) == int'(weight_k_q))
  // The remaining weight never exceeds the remaining positions.
  `CU_ASSERT_NOW(a_k_fits, state_q == S_STEP_RD, kcur_q <= pos_left_q)
  // The position marker walks as a single bit.
  `CU_ASSERT_NOW(a_mask_onehot, state_q == S_STEP_RD || state_q == S_STEP, $onehot0(mask_q))
  // After a transfer the block is busy in the following cycle.
  `CU_ASSERT_NEXT(a_busy_after_take, rank_valid_i && rank_ready_o, !rank_ready_o)

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import cu_pkg::*;

  localparam int unsigned MAX_LEN        = MAX_LEN_DEF;
  localparam logic [63:0] BINOM_CAP      = 64'h3f3f3f3f3f3f3f3f;
  localparam int unsigned RANDOM_ITEMS   = 1100;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned WATCHDOG_LIMIT = 40000;

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum int unsigned {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [DATA_W-1:0] bits;
    logic              bad;
  } unrank_res_t;

  typedef struct {
    logic [CFG_W-1:0]  n;
    logic [CFG_W-1:0]  k;
    bit                spare;
    logic [DATA_W-1:0] rank;
    bit                known;
    unrank_res_t       typed;
  } probe_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [CFG_W-1:0]     cfg_data_i   = '0;
  logic                 rank_valid_i = 1'b0;
  logic                 rank_ready_o;
  logic [DATA_W-1:0]    rank_index_i = '0;
  logic                 res_valid_o;
  logic                 res_ready_i  = 1'b0;
  logic [DATA_W-1:0]    combination_bits_o;
  logic                 bad_rank_o;

  // Testbench-side copy of the register file and the binomial table.
  logic [63:0]          pascal [0:MAX_LEN][0:MAX_LEN];
  logic [CFG_W-1:0]     len_cfg = '0;
  logic [CFG_W-1:0]     wt_cfg  = '0;

  // Expectation that rides along with the rank currently offered.
  bit                   typed_known = 1'b0;
  unrank_res_t          typed_res   = '0;

  unrank_res_t          pending_combos [$];
  probe_t               probes [$];
  int unsigned          mismatch_cnt = 0;
  int unsigned          quiet_cycles = 0;
  bit                   hold_req     = 1'b0;

  combination_unrank i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .rank_valid_i       (rank_valid_i),
    .rank_ready_o       (rank_ready_o),
    .rank_index_i       (rank_index_i),
    .res_valid_o        (res_valid_o),
    .res_ready_i        (res_ready_i),
    .combination_bits_o (combination_bits_o),
    .bad_rank_o         (bad_rank_o)
  );

  always #2 clk_i = ~clk_i;

  // Walk the positions from the most significant one, subtracting the count of
  // strings that start with a zero whenever the rank reaches past them.
  function automatic unrank_res_t unrank_predict(input logic [DATA_W-1:0] rank);
    unrank_res_t       r;
    int unsigned       n;
    int unsigned       k;
    int unsigned       i;
    logic [DATA_W-1:0] left;
    logic [63:0]       c;
    r    = '0;
    n    = 32'(len_cfg);
    k    = 32'(wt_cfg);
    left = rank;
    if (n > MAX_LEN) begin
      r.bad = 1'b1;
      return r;
    end
    if (k > n || rank >= pascal[n][k]) begin
      r.bad = 1'b1;
      return r;
    end
    for (i = 0; i < n; i++) begin
      c = pascal[n - i - 1][k];
      if (c <= left) begin
        left -= c;
        if (k > 0) k--;
        r.bits[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void add_probe(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k,
                                    input bit spare, input logic [DATA_W-1:0] rank,
                                    input bit known, input logic [DATA_W-1:0] bits,
                                    input logic bad);
    probe_t p;
    p.n          = n;
    p.k          = k;
    p.spare      = spare;
    p.rank       = rank;
    p.known      = known;
    p.typed.bits = bits;
    p.typed.bad  = bad;
    probes.insert(probes.size(), p);
  endfunction

  // Offer one rank and hold it until the transfer; valid is left high.
  task automatic send_rank(input logic [DATA_W-1:0] rank, input bit known,
                           input unrank_res_t typed);
    rank_valid_i <= 1'b1;
    rank_index_i <= rank;
    typed_known  <= known;
    typed_res    <= typed;
    do @(posedge clk_i); while (!rank_ready_o);
  endtask

  task automatic idle_rank(input int unsigned cycles);
    rank_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    rank_valid_i <= 1'b0;
    // Let the scoreboard book a transfer taken just now before the queue is checked.
    @(posedge clk_i);
    while (pending_combos.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write enable stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k,
                              input bit spare);
    wait_all_results();
    write_reg(CFG_LENGTH_N, n);
    write_reg(CFG_WEIGHT_K, k);
    if (spare) begin
      write_reg(CFG_SPARE_A, 7'h7f);
      write_reg(CFG_SPARE_B, 7'h01);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Track register writes, predict at each rank transfer, check each result.
  always @(posedge clk_i) begin : scoreboard
    unrank_res_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LENGTH_N: len_cfg = cfg_data_i;
          CFG_WEIGHT_K: wt_cfg  = cfg_data_i;
          default: ;
        endcase
      end
      if (rank_valid_i && rank_ready_o) begin
        pending_combos.insert(pending_combos.size(),
                              typed_known ? typed_res : unrank_predict(rank_index_i));
      end
      if (res_valid_o && res_ready_i) begin
        if (pending_combos.size() == 0) begin
          $display("%0t: unexpected result, bits %h bad %b", $time,
                   combination_bits_o, bad_rank_o);
          mismatch_cnt++;
        end else begin
          want = pending_combos.pop_front();
          if (combination_bits_o !== want.bits) begin
            $display("%0t: combination_bits expected %h, got %h", $time,
                     want.bits, combination_bits_o);
            mismatch_cnt++;
          end
          if (bad_rank_o !== want.bad) begin
            $display("%0t: bad_rank expected %b, got %b", $time, want.bad, bad_rank_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // End the run if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((rank_valid_i && rank_ready_o) || (res_valid_o && res_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: spans of different stall patterns, plus a long hold-off on request.
  initial begin : rx_stall
    rx_mode_e    mode;
    int unsigned span;
    int unsigned j;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(4, 80);
      for (j = 0; j < span; j++) begin
        @(posedge clk_i);
        if (hold_req) begin
          res_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_req = 1'b0;
        end else begin
          case (mode)
            RX_ALWAYS:   res_ready_i <= 1'b1;
            RX_HALF:     res_ready_i <= ($urandom_range(0, 1) != 0);
            RX_SPARSE:   res_ready_i <= ($urandom_range(0, 3) == 0);
            default:     res_ready_i <= (j % 3 == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0]  cur_n;
    logic [CFG_W-1:0]  cur_k;
    logic [CFG_W-1:0]  n;
    logic [CFG_W-1:0]  k;
    logic [DATA_W-1:0] span_c;
    logic [DATA_W-1:0] rank;
    logic [63:0]       s;
    int unsigned       i;
    int unsigned       j;
    int unsigned       phase;
    int unsigned       count;
    int unsigned       left_in_phase;
    int unsigned       burst_left;

    // Pascal triangle with saturation, zero above the diagonal.
    for (i = 0; i <= MAX_LEN; i++) begin
      for (j = 0; j <= MAX_LEN; j++) pascal[i][j] = '0;
      pascal[i][0] = 64'd1;
    end
    for (i = 1; i <= MAX_LEN; i++) begin
      for (j = 1; j <= i; j++) begin
        s = pascal[i-1][j] + pascal[i-1][j-1];
        pascal[i][j] = (s > BINOM_CAP) ? BINOM_CAP : s;
      end
    end

    // Directed cases: reset settings, extremes, invalid settings and ranks.
    add_probe(0, 0, 0, 64'd0, 1, 64'd0, 1'b0);
    add_probe(0, 0, 0, 64'd1, 1, 64'd0, 1'b1);
    add_probe(0, 0, 0, '1, 1, 64'd0, 1'b1);
    add_probe(64, 64, 0, 64'd0, 1, '1, 1'b0);
    add_probe(64, 64, 0, 64'd1, 1, 64'd0, 1'b1);
    add_probe(64, 0, 0, 64'd0, 1, 64'd0, 1'b0);
    add_probe(64, 1, 0, 64'd0, 1, 64'h8000_0000_0000_0000, 1'b0);
    add_probe(64, 1, 0, 64'd63, 1, 64'd1, 1'b0);
    add_probe(64, 1, 0, 64'd64, 1, 64'd0, 1'b1);
    add_probe(64, 32, 0, 64'd0, 0, '0, 1'b0);
    add_probe(64, 32, 0, pascal[64][32] - 1, 0, '0, 1'b0);
    add_probe(64, 32, 0, pascal[64][32], 1, 64'd0, 1'b1);
    add_probe(64, 32, 0, 64'h5555_5555_5555_5555, 0, '0, 1'b0);
    add_probe(64, 63, 0, 64'd0, 0, '0, 1'b0);
    // Weight above length.
    add_probe(10, 11, 0, 64'd0, 1, 64'd0, 1'b1);
    // Length above the largest supported one.
    add_probe(127, 0, 0, 64'd0, 1, 64'd0, 1'b1);
    add_probe(65, 3, 0, 64'd5, 1, 64'd0, 1'b1);
    // Writes to unmapped indexes right after a valid setting.
    add_probe(5, 2, 1, 64'd9, 0, '0, 1'b0);
    add_probe(5, 2, 0, 64'd10, 1, 64'd0, 1'b1);
    add_probe(1, 1, 0, 64'd0, 1, 64'd1, 1'b0);
    add_probe(1, 1, 0, 64'd1, 1, 64'd0, 1'b1);
    add_probe(1, 0, 0, 64'd0, 1, 64'd0, 1'b0);
    add_probe(32, 16, 0, 64'hAAAA_AAAA_AAAA_AAAA, 1, 64'd0, 1'b1);
    add_probe(32, 16, 0, 64'd12345, 0, '0, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block fills its table before it takes the first rank.
    do @(posedge clk_i); while (!rank_ready_o);

    cur_n = '0;
    cur_k = '0;
    foreach (probes[p]) begin
      if (probes[p].n != cur_n || probes[p].k != cur_k || probes[p].spare) begin
        apply_config(probes[p].n, probes[p].k, probes[p].spare);
        cur_n = probes[p].n;
        cur_k = probes[p].k;
      end
      send_rank(probes[p].rank, probes[p].known, probes[p].typed);
      if ($urandom_range(0, 1) != 0) idle_rank($urandom_range(1, 3));
    end

    // Random phases, each with its own setting and a mix of in-range ranks and noise.
    count      = 0;
    phase      = 0;
    burst_left = 0;
    while (count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0: begin n = 64; k = 32; end
        1: begin n = 64; k = CFG_W'($urandom_range(0, 64)); end
        2: begin n = 64; k = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'd0; end
        3: begin
          n = CFG_W'($urandom_range(0, 2));
          k = CFG_W'($urandom_range(0, n));
        end
        4: begin
          n = CFG_W'($urandom_range(0, 63));
          k = CFG_W'($urandom_range(n + 1, 127));
        end
        5: begin
          n = CFG_W'($urandom_range(MAX_LEN + 1, 127));
          k = CFG_W'($urandom_range(0, 127));
        end
        default: begin
          n = CFG_W'($urandom_range(0, 64));
          k = CFG_W'($urandom_range(0, n));
        end
      endcase
      apply_config(n, k, (phase % 5) == 2);
      // Stall the result side for a long time while ranks keep coming.
      if (phase == 3 || phase == 12) hold_req = 1'b1;

      left_in_phase = $urandom_range(20, 70);
      while (left_in_phase != 0 && count < RANDOM_ITEMS) begin
        if (n <= MAX_LEN && k <= n) begin
          span_c = pascal[n][k];
          case ($urandom_range(0, 15))
            0:       rank = '0;
            1:       rank = span_c - 1;
            2:       rank = span_c;
            3:       rank = {$urandom, $urandom};
            default: rank = {$urandom, $urandom} % span_c;
          endcase
        end else begin
          rank = {$urandom, $urandom};
        end
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
          if (!hold_req) idle_rank($urandom_range(1, 12));
        end
        burst_left--;
        send_rank(rank, 1'b0, '0);
        left_in_phase--;
        count++;
        // Now and then pause until the block has returned everything.
        if (left_in_phase == 10 && !hold_req && $urandom_range(0, 3) == 0) begin
          wait_all_results();
        end
      end
      phase++;
    end

    wait_all_results();
    repeat (2 * MAX_LEN + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
